// ===== src/spg_pkg.sv =====
// Shared types and constants for the stepper pulse generator.
package spg_pkg;

	localparam int SPG_POSITION_BITS = 32;
	localparam int FIELD_BITS        = 32;

	localparam int OFF_CEIL     = 200;
	localparam int OFF_FLOOR    = 5;
	localparam int PERCENT_SPAN = 100;
	localparam int DELAY_SPAN   = 195;
	// floor(x / 100) == (x * 5243) >> 19 for x below 19,600
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;

	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	localparam logic [2:0] REG_ON_TIME    = 3'd0;
	localparam logic [2:0] REG_SPEED_GAIN = 3'd1;
	localparam logic [2:0] REG_TOLERANCE  = 3'd2;
	localparam logic [2:0] REG_FLIP_DIR   = 3'd3;
	localparam logic [2:0] REG_ENC_MODE   = 3'd4;

	localparam logic [7:0]  ON_TIME_RST    = 8'd1;
	localparam logic [7:0]  SPEED_GAIN_RST = 8'd1;
	localparam logic [15:0] TOLERANCE_RST  = 16'd1;

	typedef struct packed {
		logic [7:0]  on_time;
		logic [7:0]  speed_gain;
		logic [15:0] tolerance;
		logic        dir_invert;
		logic        encoder_mode;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic ld_err;
		logic ld_mul;
		logic ld_scl;
		logic ld_off;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic is_target;
	} sts_t;

endpackage

// ===== src/spg_if.sv =====
// Request and response channel interfaces.
interface spg_req_if
	import spg_pkg::*;
	();
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic signed [FIELD_BITS-1:0] target_position;
	logic signed [FIELD_BITS-1:0] encoder_count;

	modport source(output valid, func, target_position, encoder_count, input ready);
	modport sink(input valid, func, target_position, encoder_count, output ready);
endinterface

interface spg_rsp_if
	import spg_pkg::*;
	();
	logic                         valid;
	logic                         ready;
	logic                         step_out;
	logic                         dir_out;
	logic signed [FIELD_BITS-1:0] position;

	modport source(output valid, step_out, dir_out, position, input ready);
	modport sink(input valid, step_out, dir_out, position, output ready);
endinterface

// ===== src/spg_regs.sv =====
// APB configuration register file.
module spg_regs
	import spg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_time      <= ON_TIME_RST;
			cfg_q.speed_gain   <= SPEED_GAIN_RST;
			cfg_q.tolerance    <= TOLERANCE_RST;
			cfg_q.dir_invert   <= 1'b0;
			cfg_q.encoder_mode <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_ON_TIME:    cfg_q.on_time      <= pwdata[7:0];
				REG_SPEED_GAIN: cfg_q.speed_gain   <= pwdata[7:0];
				REG_TOLERANCE:  cfg_q.tolerance    <= pwdata[15:0];
				REG_FLIP_DIR:   cfg_q.dir_invert   <= pwdata[0];
				REG_ENC_MODE:   cfg_q.encoder_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ON_TIME:    prdata = DATA_BITS'(cfg_q.on_time);
			REG_SPEED_GAIN: prdata = DATA_BITS'(cfg_q.speed_gain);
			REG_TOLERANCE:  prdata = DATA_BITS'(cfg_q.tolerance);
			REG_FLIP_DIR:   prdata = DATA_BITS'(cfg_q.dir_invert);
			REG_ENC_MODE:   prdata = DATA_BITS'(cfg_q.encoder_mode);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== src/spg_ctrl.sv =====
// Sequencing controller: request intake, off-delay steps, response slot.
module spg_ctrl
	import spg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ERR  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SCL  = 3'd3;
	localparam logic [2:0] ST_OFF  = 3'd4;
	localparam logic [2:0] ST_UPD  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_ERR;
				end
			end
			ST_ERR: begin
				cmd.ld_err = 1'b1;
				state_d    = sts.is_target ? ST_UPD : ST_MUL;
			end
			ST_MUL: begin
				cmd.ld_mul = 1'b1;
				state_d    = ST_SCL;
			end
			ST_SCL: begin
				cmd.ld_scl = 1'b1;
				state_d    = ST_OFF;
			end
			ST_OFF: begin
				cmd.ld_off = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				if (slot_free) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/spg_dp.sv =====
// Datapath: position state, off-delay arithmetic and step timer.
module spg_dp
	import spg_pkg::*;
#(
	parameter int POSITION_BITS = SPG_POSITION_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	input  cfg_t                         cfg,
	input  logic                         req_func,
	input  logic signed [FIELD_BITS-1:0] req_target,
	input  logic signed [FIELD_BITS-1:0] req_encoder,
	output logic                         step_out,
	output logic                         dir_out,
	output logic signed [FIELD_BITS-1:0] position
);

	localparam int PB = POSITION_BITS;
	localparam int PW = PB + 8;
	localparam int WW = PB + 17;

	logic                 func_q;
	logic signed [PB-1:0] tgt_q, enc_q;
	logic [PB-1:0]        err_q;
	logic [PW-1:0]        prod_q;
	logic                 big_q;
	logic [14:0]          scl_q;
	logic [7:0]           off_q;

	logic signed [PB-1:0] cur_q, des_q;
	logic [7:0]           timer_q;
	logic                 step_q, dir_q, fwd_q;

	logic signed [PB:0]   diff;
	logic [27:0]          quot_full;
	logic [7:0]           quot;

	logic signed [PB-1:0] cur_n;
	logic signed [WW-1:0] cur_w, des_w, tol_w;
	logic                 in_band;
	logic signed [PB-1:0] cur_d, des_d;
	logic [7:0]           timer_d;
	logic                 step_d, dir_d, fwd_d;

	assign sts.is_target = func_q;
	assign step_out      = step_q;
	assign dir_out       = dir_q;
	assign position      = FIELD_BITS'(cur_q);

	assign diff      = (PB+1)'(des_q) - (PB+1)'(cur_q);
	assign quot_full = 28'(scl_q) * 28'(RECIP_100);
	assign quot      = quot_full[RECIP_SHIFT +: 8];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= req_func;
			tgt_q  <= req_target[PB-1:0];
			enc_q  <= req_encoder[PB-1:0];
		end
		if (cmd.ld_err)
			err_q <= diff[PB] ? PB'(-diff) : diff[PB-1:0];
		if (cmd.ld_mul)
			prod_q <= PW'(cfg.speed_gain) * PW'(err_q);
		if (cmd.ld_scl) begin
			big_q <= prod_q > PW'(PERCENT_SPAN);
			scl_q <= 15'(prod_q[6:0]) * 15'(DELAY_SPAN);
		end
		if (cmd.ld_off)
			off_q <= big_q ? 8'(OFF_FLOOR) : 8'(OFF_CEIL) - quot;
	end

	assign cur_n = cfg.encoder_mode ? enc_q : cur_q;
	assign cur_w = WW'(cur_n);
	assign des_w = WW'(des_q);
	assign tol_w = $signed(WW'(cfg.tolerance));
	assign in_band = (cur_w > des_w - tol_w) && (cur_w < des_w + tol_w);

	always_comb begin
		cur_d   = cur_q;
		des_d   = des_q;
		timer_d = timer_q;
		step_d  = step_q;
		dir_d   = dir_q;
		fwd_d   = fwd_q;
		if (func_q) begin
			des_d = tgt_q;
			if (cur_q < tgt_q) begin
				dir_d = cfg.dir_invert;
				fwd_d = 1'b1;
			end else begin
				dir_d = !cfg.dir_invert;
				fwd_d = 1'b0;
			end
		end else begin
			cur_d = cur_n;
			if (step_q && timer_q > cfg.on_time) begin
				step_d  = 1'b0;
				timer_d = '0;
			end else if (timer_q > off_q) begin
				timer_d = '0;
				if (cfg.encoder_mode) begin
					if (cur_n < des_q) begin
						dir_d  = cfg.dir_invert;
						step_d = 1'b1;
						fwd_d  = 1'b1;
					end else if (cur_n > des_q) begin
						dir_d  = !cfg.dir_invert;
						step_d = 1'b1;
					end
				end else if (!in_band) begin
					cur_d  = fwd_q ? cur_q + PB'(1) : cur_q - PB'(1);
					step_d = 1'b1;
				end
			end else begin
				timer_d = timer_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			des_q   <= '0;
			timer_q <= '0;
			step_q  <= 1'b0;
			dir_q   <= 1'b0;
			fwd_q   <= 1'b1;
		end else if (cmd.update) begin
			cur_q   <= cur_d;
			des_q   <= des_d;
			timer_q <= timer_d;
			step_q  <= step_d;
			dir_q   <= dir_d;
			fwd_q   <= fwd_d;
		end
	end

endmodule

// ===== src/stepper_pulse_generator.sv =====
// Top level of the step/direction pulse generator.
//
// Requests arrive on req: func 1 loads target_position as the new set point,
// func 0 is a timer tick (encoder_count is sampled on ticks in encoder mode).
// Every request yields exactly one response on rsp: step and direction pin
// levels and the current position, sign-extended to 32 bits.
// Configuration goes through the APB port, one register per word address;
// pready is tied high and writes are meant for when the block is idle.
// One request is worked at a time. The sequencer walks a set point through its
// error and update steps, and a tick through the error, gain multiply, scaling,
// reciprocal divide and update steps; the response is registered after update.
// req.ready rises again together with rsp.valid, so a new request is taken
// while the response still waits in its output register.
// If rsp is stalled, a finished request holds in its last step until the
// response slot drains; the response is held stable meanwhile.
// Reset (arst_n low) clears position, target, timer and pin levels, sets the
// motion direction forward and restores the register defaults.
module stepper_pulse_generator
	import spg_pkg::*;
#(
	parameter int POSITION_BITS = SPG_POSITION_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	spg_req_if.sink              req,
	spg_rsp_if.source            rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	spg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	spg_dp #(
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg         (cfg),
		.req_func    (req.func),
		.req_target  (req.target_position),
		.req_encoder (req.encoder_count),
		.step_out    (rsp.step_out),
		.dir_out     (rsp.dir_out),
		.position    (rsp.position)
	);

endmodule

// ===== src/spg_checker.sv =====
// Port-level assertions for the pulse generator, bound to the top level.
module spg_checker
	import spg_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  rsp_step,
	input logic                  rsp_dir,
	input logic [FIELD_BITS-1:0] rsp_pos,
	input logic                  pready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step) && $stable(rsp_dir)
			&& $stable(rsp_pos))
		else $error("response changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("response appeared without a request in progress");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("configuration port inserted wait state");

endmodule

bind stepper_pulse_generator spg_checker u_spg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_step  (rsp.step_out),
	.rsp_dir   (rsp.dir_out),
	.rsp_pos   (rsp.position),
	.pready    (pready)
);
